// ===== design/ooks_pkg.sv =====
// Shared types, constants and a helper function for the OOK pulse timer with RSSI statistics.
`default_nettype none

package ooks_pkg;

    localparam int VOTE_LEN  = 5;
    localparam int VOTE_HALF = VOTE_LEN / 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd2;

    localparam logic [7:0]  RST_SAMPLE_PERIOD = 8'd25;
    localparam logic [15:0] RST_QUIET_LIMIT   = 16'd400;
    localparam logic [15:0] RST_WINDOW_LEN    = 16'd40000;

    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int STD_MAX = 10;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    typedef struct packed {
        logic       data_bit;
        logic [7:0] rssi_raw;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [15:0] pulse_us;
        logic        pulse_level;
        logic [7:0]  rssi_mean;
        logic [31:0] rssi_variance;
        logic [3:0]  rssi_stddev;
        logic [15:0] edge_count;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        OUT_PULSE,
        OUT_TAIL,
        OUT_STATS
    } t_out_sel;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_SCALED,
        DIV_VAR
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_EDGE,
        S_FLUSH_HEAD,
        S_FLUSH_TAIL,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SCALED_GO,
        S_SCALED_WAIT,
        S_NUM,
        S_VAR_GO,
        S_VAR_WAIT,
        S_STATS
    } t_state;

    typedef struct packed {
        logic     sample;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_mean;
        logic     cap_scaled;
        logic     cap_num;
        logic     cap_var;
    } t_cmd;

    typedef struct packed {
        logic edge_seen;
        logic flush;
        logic close;
        logic out_free;
        logic div_done;
    } t_status;

    function automatic logic [3:0] stddev_of(input logic [31:0] var_in);
        logic [3:0] s;
        s = 4'(STD_MAX);
        for (int i = STD_MAX - 1; i >= 1; i--) begin
            if (var_in <= 32'(i * i)) begin
                s = 4'(i);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/ook_pulse_timer_rssi_stats_top.sv =====
// Top level of the OOK pulse timer with RSSI window statistics.
// A sample with no result passes through the idle and decide states; each pulse result adds
// an output state that waits for a free output. A sample that closes a window also runs three
// passes through the shared divider at one quotient bit per cycle. Pulse results and the
// statistics result are held in the output register and wait while the output is stalled.
// Reset is synchronous and active low; it restores register defaults and clears control and sample state.
`default_nettype none

module ook_pulse_timer_rssi_stats_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ooks_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ooks_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire ooks_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output ooks_pkg::t_out                       o_out_data
);

    ooks_pkg::t_cmd    cmd;
    ooks_pkg::t_status status;
    logic              ready;

    ooks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    ooks_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !ready;

endmodule

`default_nettype wire

// ===== design/ooks_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the window statistics.
`default_nettype none

module ooks_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ooks_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [ooks_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                               o_done,
    output logic [ooks_pkg::DIV_W-1:0]          o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [ooks_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [ooks_pkg::DIVISOR_W-1:0]     r_rem;
    logic [ooks_pkg::DIVISOR_W-1:0]     r_dvs;
    logic [ooks_pkg::DIV_W-1:0]         r_quo;

    logic [ooks_pkg::DIVISOR_W:0]       rem_sh;
    logic [ooks_pkg::DIVISOR_W:0]       diff;
    logic                               ge;
    logic [ooks_pkg::DIVISOR_W-1:0]     n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[ooks_pkg::DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? diff[ooks_pkg::DIVISOR_W-1:0] : rem_sh[ooks_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ooks_pkg::DIV_CNT_W'(ooks_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ooks_pkg::DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/ooks_dp.sv =====
// Datapath: sample filter, pulse timing, RSSI accumulation, statistics and output register.
`default_nettype none

module ooks_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ooks_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ooks_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire ooks_pkg::t_in                      i_in_data,
    input  wire ooks_pkg::t_cmd                     i_cmd,
    output ooks_pkg::t_status                       o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output ooks_pkg::t_out                          o_out_data
);

    logic [7:0]  r_period;
    logic [15:0] r_quiet_limit;
    logic [15:0] r_window_len;

    logic [ooks_pkg::VOTE_LEN-1:0] r_hist;
    logic        r_held;
    logic [15:0] r_ticks;
    logic [15:0] r_quiet;
    logic [31:0] r_sum;
    logic [31:0] r_sq;
    logic [15:0] r_samples;
    logic [15:0] r_edges;

    logic [15:0] r_pulse_ticks;
    logic        r_pulse_level;
    logic        r_edge_seen;
    logic        r_flush;
    logic        r_close;

    logic [31:0] r_w_sum;
    logic [31:0] r_w_sq;
    logic [15:0] r_w_n;
    logic [15:0] r_w_edges;
    logic [7:0]  r_mean;
    logic [31:0] r_scaled;
    logic [31:0] r_num;
    logic [31:0] r_var;

    logic           r_out_valid;
    ooks_pkg::t_out r_out;

    logic [ooks_pkg::VOTE_LEN-1:0] n_hist;
    logic        level;
    logic        edge_now;
    logic [15:0] ticks_inc;
    logic [15:0] quiet_inc;
    logic        quiet_sat;
    logic        flush_now;
    logic [7:0]  rssi;
    logic [15:0] rssi_sq;
    logic [31:0] n_sum;
    logic [31:0] n_sq;
    logic [15:0] n_samples;
    logic [15:0] n_edges;
    logic        close_now;

    logic [23:0] pulse_prod;
    logic [15:0] pulse_us;
    logic [55:0] num_prod;

    logic [ooks_pkg::DIV_W-1:0]     div_dividend;
    logic [ooks_pkg::DIVISOR_W-1:0] div_divisor;
    logic                           div_done;
    logic [ooks_pkg::DIV_W-1:0]     div_quotient;

    ooks_pkg::t_out n_out;

    always_comb begin
        n_hist    = (r_hist << 1) | ooks_pkg::VOTE_LEN'(i_in_data.data_bit);
        level     = ($countones(n_hist) > ooks_pkg::VOTE_HALF);
        edge_now  = (level != r_held);
        ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
        quiet_sat = (r_quiet == 16'hFFFF);
        quiet_inc = r_quiet + 16'd1;
        flush_now = !edge_now && !quiet_sat && (quiet_inc == r_quiet_limit);
        rssi      = ~i_in_data.rssi_raw;
        rssi_sq   = {8'd0, rssi} * {8'd0, rssi};
        n_sum     = r_sum + {24'd0, rssi};
        n_sq      = r_sq + {16'd0, rssi_sq};
        n_samples = r_samples + 16'd1;
        n_edges   = edge_now ? r_edges + 16'd1 : r_edges;
        close_now = (n_samples >= r_window_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= ooks_pkg::RST_SAMPLE_PERIOD;
            r_quiet_limit <= ooks_pkg::RST_QUIET_LIMIT;
            r_window_len  <= ooks_pkg::RST_WINDOW_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ooks_pkg::CFG_SAMPLE_PERIOD: r_period      <= i_cfg_data[7:0];
                ooks_pkg::CFG_QUIET_LIMIT:   r_quiet_limit <= i_cfg_data;
                ooks_pkg::CFG_WINDOW_LEN:    r_window_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_held      <= 1'b0;
            r_ticks     <= '0;
            r_quiet     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_samples   <= '0;
            r_edges     <= '0;
            r_edge_seen <= 1'b0;
            r_flush     <= 1'b0;
            r_close     <= 1'b0;
        end else if (i_cmd.sample) begin
            r_hist      <= n_hist;
            r_edge_seen <= edge_now;
            r_flush     <= flush_now;
            r_close     <= close_now;
            if (edge_now) begin
                r_ticks <= '0;
                r_held  <= level;
                r_quiet <= '0;
            end else begin
                r_ticks <= ticks_inc;
                if (!quiet_sat) begin
                    r_quiet <= quiet_inc;
                end
            end
            if (close_now) begin
                r_sum     <= '0;
                r_sq      <= '0;
                r_samples <= '0;
                r_edges   <= '0;
            end else begin
                r_sum     <= n_sum;
                r_sq      <= n_sq;
                r_samples <= n_samples;
                r_edges   <= n_edges;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_pulse_ticks <= ticks_inc;
            r_pulse_level <= r_held;
            if (close_now) begin
                r_w_sum   <= n_sum;
                r_w_sq    <= n_sq;
                r_w_n     <= n_samples;
                r_w_edges <= n_edges;
            end
        end
        if (i_cmd.cap_mean) begin
            r_mean <= div_quotient[7:0];
        end
        if (i_cmd.cap_scaled) begin
            r_scaled <= div_quotient;
        end
        if (i_cmd.cap_num) begin
            r_num <= r_w_sq - num_prod[31:0];
        end
        if (i_cmd.cap_var) begin
            r_var <= div_quotient;
        end
    end

    assign num_prod = 56'(r_w_sum[31:8]) * 56'(r_scaled);

    always_comb begin
        unique case (i_cmd.div_sel)
            ooks_pkg::DIV_MEAN: begin
                div_dividend = r_w_sum;
                div_divisor  = r_w_n;
            end
            ooks_pkg::DIV_SCALED: begin
                div_dividend = {r_w_sum[23:0], 8'd0};
                div_divisor  = r_w_n;
            end
            ooks_pkg::DIV_VAR: begin
                div_dividend = r_num;
                div_divisor  = r_w_n - 16'd1;
            end
            default: begin
                div_dividend = r_w_sum;
                div_divisor  = r_w_n;
            end
        endcase
    end

    ooks_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        pulse_prod = {8'd0, r_pulse_ticks} * {16'd0, r_period};
        pulse_us   = (pulse_prod > 24'd65535) ? 16'hFFFF : pulse_prod[15:0];
        n_out      = '0;
        n_out.last = i_cmd.out_last;
        unique case (i_cmd.out_sel)
            ooks_pkg::OUT_PULSE: begin
                n_out.kind        = ooks_pkg::KIND_PULSE;
                n_out.pulse_us    = pulse_us;
                n_out.pulse_level = r_pulse_level;
            end
            ooks_pkg::OUT_TAIL: begin
                n_out.kind        = ooks_pkg::KIND_PULSE;
                n_out.pulse_us    = 16'd1;
                n_out.pulse_level = ~r_pulse_level;
            end
            ooks_pkg::OUT_STATS: begin
                n_out.kind          = ooks_pkg::KIND_STATS;
                n_out.rssi_mean     = r_mean;
                n_out.rssi_variance = r_var;
                n_out.rssi_stddev   = ooks_pkg::stddev_of(r_var);
                n_out.edge_count    = r_w_edges;
            end
            default: begin
                n_out.kind = ooks_pkg::KIND_PULSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_status.edge_seen = r_edge_seen;
        o_status.flush     = r_flush;
        o_status.close     = r_close;
        o_status.out_free  = !r_out_valid || !i_out_stall;
        o_status.div_done  = div_done;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/ooks_ctrl.sv =====
// Controller state machine that sequences sample intake, result emission and statistics.
`default_nettype none

module ooks_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire ooks_pkg::t_status i_status,
    output logic                   o_ready,
    output ooks_pkg::t_cmd         o_cmd
);

    ooks_pkg::t_state r_state;
    ooks_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ooks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ooks_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ooks_pkg::S_DECIDE;
            end
            ooks_pkg::S_DECIDE: begin
                if (i_status.edge_seen)  n_state = ooks_pkg::S_EDGE;
                else if (i_status.flush) n_state = ooks_pkg::S_FLUSH_HEAD;
                else if (i_status.close) n_state = ooks_pkg::S_MEAN_GO;
                else                     n_state = ooks_pkg::S_IDLE;
            end
            ooks_pkg::S_EDGE: begin
                if (i_status.out_free) begin
                    n_state = i_status.close ? ooks_pkg::S_MEAN_GO : ooks_pkg::S_IDLE;
                end
            end
            ooks_pkg::S_FLUSH_HEAD: begin
                if (i_status.out_free) n_state = ooks_pkg::S_FLUSH_TAIL;
            end
            ooks_pkg::S_FLUSH_TAIL: begin
                if (i_status.out_free) begin
                    n_state = i_status.close ? ooks_pkg::S_MEAN_GO : ooks_pkg::S_IDLE;
                end
            end
            ooks_pkg::S_MEAN_GO:   n_state = ooks_pkg::S_MEAN_WAIT;
            ooks_pkg::S_MEAN_WAIT: begin
                if (i_status.div_done) n_state = ooks_pkg::S_SCALED_GO;
            end
            ooks_pkg::S_SCALED_GO: n_state = ooks_pkg::S_SCALED_WAIT;
            ooks_pkg::S_SCALED_WAIT: begin
                if (i_status.div_done) n_state = ooks_pkg::S_NUM;
            end
            ooks_pkg::S_NUM:    n_state = ooks_pkg::S_VAR_GO;
            ooks_pkg::S_VAR_GO: n_state = ooks_pkg::S_VAR_WAIT;
            ooks_pkg::S_VAR_WAIT: begin
                if (i_status.div_done) n_state = ooks_pkg::S_STATS;
            end
            ooks_pkg::S_STATS: begin
                if (i_status.out_free) n_state = ooks_pkg::S_IDLE;
            end
            default: n_state = ooks_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = ooks_pkg::OUT_PULSE;
        o_cmd.div_sel = ooks_pkg::DIV_MEAN;
        o_ready       = 1'b0;
        unique case (r_state)
            ooks_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.sample = i_in_valid;
            end
            ooks_pkg::S_DECIDE: begin
            end
            ooks_pkg::S_EDGE: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_last = !i_status.close;
            end
            ooks_pkg::S_FLUSH_HEAD: begin
                o_cmd.out_load = i_status.out_free;
            end
            ooks_pkg::S_FLUSH_TAIL: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = ooks_pkg::OUT_TAIL;
                o_cmd.out_last = !i_status.close;
            end
            ooks_pkg::S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
            end
            ooks_pkg::S_MEAN_WAIT: begin
                o_cmd.cap_mean = i_status.div_done;
            end
            ooks_pkg::S_SCALED_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = ooks_pkg::DIV_SCALED;
            end
            ooks_pkg::S_SCALED_WAIT: begin
                o_cmd.div_sel    = ooks_pkg::DIV_SCALED;
                o_cmd.cap_scaled = i_status.div_done;
            end
            ooks_pkg::S_NUM: begin
                o_cmd.cap_num = 1'b1;
            end
            ooks_pkg::S_VAR_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = ooks_pkg::DIV_VAR;
            end
            ooks_pkg::S_VAR_WAIT: begin
                o_cmd.div_sel = ooks_pkg::DIV_VAR;
                o_cmd.cap_var = i_status.div_done;
            end
            ooks_pkg::S_STATS: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = ooks_pkg::OUT_STATS;
                o_cmd.out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
